// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/spc_pkg.sv =====
package spc_pkg;

   localparam int HALF_W = 64;
   localparam int SNAP_W = 128;
   localparam int IDX_W  = 7;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   typedef logic [2:0] lifecycle_type;

   localparam lifecycle_type LC_UNCHANGED = 3'd0;
   localparam lifecycle_type LC_MODIFIED  = 3'd1;
   localparam lifecycle_type LC_NEW       = 3'd2;
   localparam lifecycle_type LC_DELETED   = 3'd3;
   localparam lifecycle_type LC_GAP       = 3'd4;

   typedef logic [0:0] reg_index_type;

   localparam reg_index_type REG_RANGE_FIRST = 1'd0;
   localparam reg_index_type REG_RANGE_LAST  = 1'd1;

   typedef struct packed {
      logic [IDX_W-1:0] range_first;
      logic [IDX_W-1:0] range_last;
   } cfg_type;

   typedef struct packed {
      logic             in_window;
      logic [IDX_W-1:0] first_snapshot;
      logic [IDX_W-1:0] last_snapshot;
      lifecycle_type    lifecycle_class;
      logic [IDX_W-1:0] deleted_snapshot;
   } rsp_payload_type;

endpackage

// ===== rtl/spc_if.sv =====
interface spc_req_if import spc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] present_low;
   logic [HALF_W-1:0] present_high;
   logic [HALF_W-1:0] changed_low;
   logic [HALF_W-1:0] changed_high;

   modport source (output valid, present_low, present_high, changed_low, changed_high,
                   input ready);
   modport sink (input valid, present_low, present_high, changed_low, changed_high,
                 output ready);
endinterface

interface spc_rsp_if import spc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             in_window;
   logic [IDX_W-1:0] first_snapshot;
   logic [IDX_W-1:0] last_snapshot;
   lifecycle_type    lifecycle_class;
   logic [IDX_W-1:0] deleted_snapshot;

   modport source (output valid, in_window, first_snapshot, last_snapshot, lifecycle_class,
                   deleted_snapshot, input ready);
   modport sink (input valid, in_window, first_snapshot, last_snapshot, lifecycle_class,
                 deleted_snapshot, output ready);
endinterface

// ===== rtl/spc_csr.sv =====
module spc_csr import spc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = paddr[2];
   assign write_en = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_RANGE_FIRST: cfg_in.range_first = pwdata[IDX_W-1:0];
            REG_RANGE_LAST:  cfg_in.range_last  = pwdata[IDX_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_first <= '0;
         cfg_ff.range_last  <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_RANGE_FIRST: prdata = {{(DATA_W-IDX_W){1'b0}}, cfg_ff.range_first};
         REG_RANGE_LAST:  prdata = {{(DATA_W-IDX_W){1'b0}}, cfg_ff.range_last};
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/spc_classify.sv =====
module spc_classify import spc_pkg::*; #(
   parameter int MAX_SNAPSHOTS = 128
) (
   input  logic [SNAP_W-1:0] present,
   input  logic [SNAP_W-1:0] changed,
   input  cfg_type           cfg,
   output rsp_payload_type   result
);

   localparam int SCAN_STEPS = $clog2(SNAP_W);
   localparam logic [IDX_W-1:0] END_CAP = IDX_W'(MAX_SNAPSHOTS - 1);

   logic [IDX_W-1:0]  range_end;
   logic [SNAP_W-1:0] range_mask;
   logic [SNAP_W-1:0] p;
   logic [SNAP_W-1:0] below_incl;
   logic [SNAP_W-1:0] above_incl;
   logic [SNAP_W-1:0] below;
   logic [SNAP_W-1:0] above;
   logic [SNAP_W-1:0] low_hot;
   logic [SNAP_W-1:0] high_hot;
   logic [IDX_W-1:0]  low_pos;
   logic [IDX_W-1:0]  high_pos;
   logic              any_present;
   logic              has_gap;
   logic              has_change;

   assign range_end = (cfg.range_last > END_CAP) ? END_CAP : cfg.range_last;

   always_comb begin
      for (int i = 0; i < SNAP_W; i++) begin
         range_mask[i] = ((IDX_W + 1)'(i) >= {1'b0, cfg.range_first}) &&
                         ((IDX_W + 1)'(i) <= {1'b0, range_end});
      end
   end

   assign p = present & range_mask;

   always_comb begin
      below_incl = p;
      above_incl = p;
      for (int k = 0; k < SCAN_STEPS; k++) begin
         below_incl = below_incl | (below_incl << (1 << k));
         above_incl = above_incl | (above_incl >> (1 << k));
      end
   end

   assign below    = below_incl << 1;
   assign above    = above_incl >> 1;
   assign low_hot  = p & ~below;
   assign high_hot = p & ~above;

   always_comb begin
      low_pos  = '0;
      high_pos = '0;
      for (int i = 0; i < SNAP_W; i++) begin
         if (low_hot[i]) low_pos = low_pos | IDX_W'(i);
         if (high_hot[i]) high_pos = high_pos | IDX_W'(i);
      end
   end

   assign any_present = |p;
   assign has_gap     = |(~p & below & above);
   assign has_change  = |(changed & below & range_mask);

   always_comb begin
      result = '0;
      if (any_present) begin
         result.in_window      = 1'b1;
         result.first_snapshot = low_pos;
         result.last_snapshot  = high_pos;
         priority if (has_gap) begin
            result.lifecycle_class = LC_GAP;
         end else if (high_pos < range_end) begin
            result.lifecycle_class  = LC_DELETED;
            result.deleted_snapshot = high_pos + IDX_W'(1);
         end else if (low_pos == range_end) begin
            result.lifecycle_class = LC_NEW;
         end else if (has_change) begin
            result.lifecycle_class = LC_MODIFIED;
         end else begin
            result.lifecycle_class = LC_UNCHANGED;
         end
      end
   end

endmodule

// ===== rtl/snapshot_presence_classifier.sv =====
// Classifies one file record per clock cycle: each request carries the
// presence and changed bitmaps over up to 128 snapshots, and each response
// gives the first and last present snapshot inside the configured range, the
// lifecycle class and the deletion snapshot. A request is registered on entry
// and its response is registered on exit, and a new request is taken in every
// cycle while responses are taken. The range registers sit at byte addresses
// 0 and 4 and should only be written while no request is in flight.
`include "assert_macros.svh"

module snapshot_presence_classifier import spc_pkg::*; #(
   parameter int MAX_SNAPSHOTS = 128
) (
   input  logic              clock,
   input  logic              reset,
   spc_req_if.sink           req,
   spc_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type           cfg;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [SNAP_W-1:0] present_ff;
   logic [SNAP_W-1:0] present_in;
   logic [SNAP_W-1:0] changed_ff;
   logic [SNAP_W-1:0] changed_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_payload_type   rsp_data_ff;
   rsp_payload_type   rsp_data_in;
   logic              out_free;
   logic              in_free;
   logic              req_take;
   logic              rsp_load;

   spc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   spc_classify #(
      .MAX_SNAPSHOTS (MAX_SNAPSHOTS)
   ) u_classify (
      .present (present_ff),
      .changed (changed_ff),
      .cfg     (cfg),
      .result  (rsp_data_in)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign in_free   = !s1_valid_ff || out_free;
   assign req.ready = in_free;
   assign req_take  = req.valid && in_free;
   assign rsp_load  = s1_valid_ff && out_free;

   assign present_in   = {req.present_high, req.present_low};
   assign changed_in   = {req.changed_high, req.changed_low};
   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         present_ff <= present_in;
         changed_ff <= changed_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.in_window        = rsp_data_ff.in_window;
   assign rsp.first_snapshot   = rsp_data_ff.first_snapshot;
   assign rsp.last_snapshot    = rsp_data_ff.last_snapshot;
   assign rsp.lifecycle_class  = rsp_data_ff.lifecycle_class;
   assign rsp.deleted_snapshot = rsp_data_ff.deleted_snapshot;

   `ASSERT_NEXT(a_take_fills_stage, clock, reset, req_take, s1_valid_ff,
      "request lost on entry")
   `ASSERT_IMPLY(a_empty_is_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.in_window,
      rsp_data_ff.first_snapshot == '0 && rsp_data_ff.last_snapshot == '0 &&
      rsp_data_ff.lifecycle_class == LC_UNCHANGED, "nonzero fields out of range")
   `ASSERT_IMPLY(a_deleted_index, clock, reset,
      rsp_valid_ff && rsp_data_ff.lifecycle_class == LC_DELETED,
      rsp_data_ff.deleted_snapshot == rsp_data_ff.last_snapshot + IDX_W'(1),
      "deletion snapshot mismatch")
   `ASSERT_IMPLY(a_deleted_only, clock, reset,
      rsp_valid_ff && rsp_data_ff.lifecycle_class != LC_DELETED,
      rsp_data_ff.deleted_snapshot == '0, "deletion snapshot without deletion")
   `ASSERT_IMPLY(a_order, clock, reset, rsp_valid_ff && rsp_data_ff.in_window,
      rsp_data_ff.first_snapshot <= rsp_data_ff.last_snapshot, "first snapshot after last")

endmodule

// ===== dv/snapshot_presence_classifier_checker.sv =====
module snapshot_presence_classifier_checker import spc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   spc_req_if                req,
   spc_rsp_if                rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output int                fail_count,
   output int                pending,
   output int                checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type         range_cfg;
   rsp_payload_type expected_results[$];
   int              errors = 0;
   int              checked = 0;

   assign fail_count    = errors;
   assign checked_count = checked;

   function automatic logic [SNAP_W-1:0] span_bits(int a, int b);
      logic [SNAP_W-1:0] m;
      for (int i = 0; i < SNAP_W; i++) begin
         m[i] = (i >= a) && (i <= b);
      end
      return m;
   endfunction

   function automatic rsp_payload_type classify_record(logic [SNAP_W-1:0] present,
                                                       logic [SNAP_W-1:0] changed,
                                                       cfg_type cfg);
      rsp_payload_type   r;
      logic [SNAP_W-1:0] masked;
      int                lo;
      int                hi;
      int                first;
      int                last;
      r = '0;
      lo = cfg.range_first;
      hi = cfg.range_last;
      if (lo > hi) return r;
      masked = present & span_bits(lo, hi);
      if (masked == '0) return r;
      first = -1;
      last = 0;
      for (int i = 0; i < SNAP_W; i++) begin
         if (masked[i]) begin
            if (first < 0) first = i;
            last = i;
         end
      end
      r.in_window = 1'b1;
      r.first_snapshot = first[IDX_W-1:0];
      r.last_snapshot = last[IDX_W-1:0];
      if (masked != span_bits(first, last)) begin
         r.lifecycle_class = LC_GAP;
      end else if (last < hi) begin
         r.lifecycle_class = LC_DELETED;
         r.deleted_snapshot = IDX_W'(last + 1);
      end else if (first == hi) begin
         r.lifecycle_class = LC_NEW;
      end else if ((changed & span_bits(first + 1, hi)) != '0) begin
         r.lifecycle_class = LC_MODIFIED;
      end else begin
         r.lifecycle_class = LC_UNCHANGED;
      end
      return r;
   endfunction

   task automatic report_fault(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want) begin
         report_fault($sformatf("response %0d: %s is %0d, expected %0d",
                                checked, name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      if (reset) begin
         range_cfg.range_first = '0;
         range_cfg.range_last = 7'd127;
         expected_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.in_window = rsp.in_window;
            got.first_snapshot = rsp.first_snapshot;
            got.last_snapshot = rsp.last_snapshot;
            got.lifecycle_class = rsp.lifecycle_class;
            got.deleted_snapshot = rsp.deleted_snapshot;
            if (expected_results.size() == 0) begin
               report_fault("response arrived with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               if ($isunknown(got)) report_fault($sformatf("response %0d has unknown bits",
                                                           checked));
               compare_field("in_window", int'(got.in_window), int'(want.in_window));
               compare_field("first_snapshot", int'(got.first_snapshot),
                             int'(want.first_snapshot));
               compare_field("last_snapshot", int'(got.last_snapshot),
                             int'(want.last_snapshot));
               compare_field("lifecycle_class", int'(got.lifecycle_class),
                             int'(want.lifecycle_class));
               compare_field("deleted_snapshot", int'(got.deleted_snapshot),
                             int'(want.deleted_snapshot));
               checked++;
            end
         end
         if (req.valid && req.ready) begin
            expected_results.push_back(classify_record({req.present_high, req.present_low},
                                                       {req.changed_high, req.changed_low},
                                                       range_cfg));
         end
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[ADDR_W-1:2]))
               REG_RANGE_FIRST: range_cfg.range_first = pwdata[IDX_W-1:0];
               REG_RANGE_LAST: range_cfg.range_last = pwdata[IDX_W-1:0];
               default: ;
            endcase
         end
      end
      pending <= expected_results.size();
   end

endmodule

// ===== dv/snapshot_presence_classifier_tb.sv =====
module snapshot_presence_classifier_tb import spc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int               fail_count;
   int               pending;
   int               checked_count;
   int               sent = 0;
   int               settings = 0;
   int               cycles = 0;
   bit               quiet = 1'b0;
   logic [IDX_W-1:0] cur_first = '0;
   logic [IDX_W-1:0] cur_last = 7'd127;

   spc_req_if req_ch ();
   spc_rsp_if rsp_ch ();

   snapshot_presence_classifier dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   snapshot_presence_classifier_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d responses outstanding.", cycles, pending);
         $display("snapshot_presence_classifier_tb failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SNAP_W-1:0] run_bits(int a, int b);
      logic [SNAP_W-1:0] m;
      for (int i = 0; i < SNAP_W; i++) begin
         m[i] = (i >= a) && (i <= b);
      end
      return m;
   endfunction

   function automatic logic [SNAP_W-1:0] rand_bits();
      logic [SNAP_W-1:0] r;
      r = {$urandom(), $urandom(), $urandom(), $urandom()};
      if ($urandom_range(0, 2) == 0) r &= {$urandom(), $urandom(), $urandom(), $urandom()};
      return r;
   endfunction

   initial begin
      logic level;
      int   left;
      level = 1'b0;
      left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (left > 0) begin
            left--;
         end else if (!level || quiet) begin
            level = 1'b1;
            left = $urandom_range(0, 30);
         end else begin
            left = pick_gap();
            if (left > 0) begin
               level = 1'b0;
               left--;
            end
         end
         rsp_ch.ready <= level;
      end
   end

   task automatic send_record(logic [SNAP_W-1:0] present, logic [SNAP_W-1:0] changed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.present_low <= present[HALF_W-1:0];
      req_ch.present_high <= present[SNAP_W-1:HALF_W];
      req_ch.changed_low <= changed[HALF_W-1:0];
      req_ch.changed_high <= changed[SNAP_W-1:HALF_W];
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [IDX_W-1:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'({idx, 2'b00});
      pwdata <= {25'($urandom()), val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic program_window(int first, int last);
      wait_drained();
      write_reg(REG_RANGE_FIRST, IDX_W'(first));
      write_reg(REG_RANGE_LAST, IDX_W'(last));
      cur_first = IDX_W'(first);
      cur_last = IDX_W'(last);
      settings++;
   endtask

   task automatic make_record(output logic [SNAP_W-1:0] p, output logic [SNAP_W-1:0] c);
      int lo;
      int hi;
      int a;
      int b;
      int h;
      int anchor;
      int pos;
      lo = cur_first;
      hi = cur_last;
      anchor = lo;
      if (lo > hi) begin
         p = rand_bits();
      end else begin
         case ($urandom_range(0, 9))
            0: p = rand_bits();
            1: p = '0;
            2, 3: begin
               a = $urandom_range(lo, hi);
               p = run_bits(a, hi);
               anchor = a;
            end
            4: begin
               p = run_bits(hi, hi);
               anchor = hi;
            end
            5, 6: begin
               b = (hi > lo) ? $urandom_range(lo, hi - 1) : hi;
               a = $urandom_range(lo, b);
               p = run_bits(a, b);
               anchor = a;
            end
            default: begin
               if (hi - lo >= 2) begin
                  a = $urandom_range(lo, hi - 2);
                  b = $urandom_range(a + 2, hi);
                  h = $urandom_range(a + 1, b - 1);
                  p = run_bits(a, b);
                  p[h] = 1'b0;
                  if ($urandom_range(0, 1)) p &= ~run_bits(h, $urandom_range(h, b - 1));
                  anchor = a;
               end else begin
                  p = rand_bits();
               end
            end
         endcase
      end
      if ($urandom_range(0, 1)) p |= rand_bits() & ~run_bits(lo, hi);
      case ($urandom_range(0, 4))
         0: c = '0;
         1: c = rand_bits();
         2: c = rand_bits() & ~run_bits(anchor + 1, hi);
         default: begin
            case ($urandom_range(0, 4))
               0: pos = anchor;
               1: pos = anchor + 1;
               2: pos = hi;
               3: pos = hi + 1;
               default: pos = $urandom_range(0, SNAP_W - 1);
            endcase
            c = '0;
            c[pos % SNAP_W] = 1'b1;
         end
      endcase
   endtask

   task automatic run_phase(int first, int last, int count, bit drain_midway);
      logic [SNAP_W-1:0] present;
      logic [SNAP_W-1:0] changed;
      program_window(first, last);
      for (int n = 0; n < count; n++) begin
         if (n % 25 == 0) quiet = ($urandom_range(0, 4) == 0);
         if (drain_midway && n == count / 2) wait_drained();
         make_record(present, changed);
         send_record(present, changed);
      end
      quiet = 1'b0;
   endtask

   task automatic run_directed();
      logic [SNAP_W-1:0] ones;
      logic [SNAP_W-1:0] upper_half;
      ones = '1;
      upper_half = {{HALF_W{1'b1}}, {HALF_W{1'b0}}};
      send_record('0, '0);
      send_record(ones, '0);
      send_record(ones, ones);
      send_record(SNAP_W'(1) << 127, ones);
      send_record(SNAP_W'(1), '0);
      send_record(~(SNAP_W'(1) << 127), '0);
      send_record((SNAP_W'(1) << 127) | SNAP_W'(1), '0);
      send_record((SNAP_W'(1) << 63) | (SNAP_W'(1) << 64), '0);
      send_record(upper_half, SNAP_W'(1) << 64);
      send_record(upper_half, SNAP_W'(1) << 65);
      send_record(upper_half, SNAP_W'(1) << 127);
      send_record(~(SNAP_W'(1) << 64), '0);
      send_record(ones, SNAP_W'(1));
      program_window(5, 5);
      send_record(SNAP_W'(1) << 5, '0);
      send_record(ones, ones);
      send_record(~(SNAP_W'(1) << 5), ones);
      program_window(10, 3);
      send_record(ones, ones);
      program_window(127, 127);
      send_record(ones, '0);
      program_window(0, 0);
      send_record(ones, ones);
      send_record(SNAP_W'(2), '0);
      program_window(0, 126);
      send_record(ones, '0);
      send_record((SNAP_W'(1) << 127) | SNAP_W'(1), '0);
   endtask

   initial begin
      int a;
      int b;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.present_low <= '0;
      req_ch.present_high <= '0;
      req_ch.changed_low <= '0;
      req_ch.changed_high <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();

      run_phase(0, 127, 110, 1'b0);
      run_phase(0, 0, 100, 1'b0);
      run_phase(127, 127, 100, 1'b0);
      run_phase(0, 63, 110, 1'b1);
      run_phase(63, 64, 100, 1'b0);
      run_phase(64, 127, 110, 1'b0);
      run_phase(100, 20, 40, 1'b0);
      for (int k = 0; k < 4; k++) begin
         a = $urandom_range(0, 127);
         b = $urandom_range(a, 127);
         run_phase(a, b, 110, k == 1);
      end

      wait_drained();
      repeat (4) @(posedge clock);

      $display("Sent %0d file records under %0d range settings; %0d responses checked.",
               sent, settings, checked_count);
      $display("Ranges covered full, single-snapshot, split-word and empty settings.");
      if (fail_count == 0) begin
         $display("snapshot_presence_classifier_tb passed");
      end else begin
         $display("snapshot_presence_classifier_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spc_pkg.sv
rtl/spc_if.sv
rtl/spc_csr.sv
rtl/spc_classify.sv
rtl/snapshot_presence_classifier.sv
dv/snapshot_presence_classifier_checker.sv
dv/snapshot_presence_classifier_tb.sv
